### rtl/sha256_pkg.sv
// SHA-256 stream hash: shared types, constants and round functions.
// Used by sha256_ctrl, sha256_dp and sha256_stream_hash; depends on nothing.
package sha256_pkg;

    localparam logic KIND_ABSORB = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [5:0] POS_LAST   = 6'd63;
    localparam logic [5:0] POS_FIRST  = 6'd0;
    localparam logic [5:0] POS_LEN    = 6'd56;
    localparam logic [2:0] POS_WRAP   = 3'b111;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } sha_state_t;

    typedef enum logic [1:0] {
        BSRC_MSG,
        BSRC_PAD,
        BSRC_ZERO,
        BSRC_LEN
    } byte_src_t;

    typedef struct packed {
        logic       buf_we;
        byte_src_t  byte_src;
        logic [5:0] buf_addr;
        logic       count_inc;
        logic       msg_clear;
        logic       work_load;
        logic       round_en;
        logic [5:0] round_idx;
        logic       chain_add;
        logic [2:0] out_idx;
    } sha_cmd_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
        return (x >> n) | (x << (6'd32 - {1'b0, n}));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
    endfunction

endpackage

### rtl/sha256_ctrl.sv
// SHA-256 stream hash controller: sequences absorb, padding, compression
// rounds and digest output. Depends on sha256_pkg.
module sha256_ctrl import sha256_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_word_index,
    output logic       m_last_word,
    input  logic [5:0] pos,
    output sha_cmd_t   cmd
);

    sha_state_t state_reg, state_next;
    sha_state_t ret_reg, ret_next;
    logic       wrap_reg, wrap_next;
    logic [5:0] pad_pos_reg, pad_pos_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] out_idx_reg, out_idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            wrap_reg    <= 1'b0;
            pad_pos_reg <= '0;
            round_reg   <= '0;
            out_idx_reg <= '0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            wrap_reg    <= wrap_next;
            pad_pos_reg <= pad_pos_next;
            round_reg   <= round_next;
            out_idx_reg <= out_idx_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        wrap_next    = wrap_reg;
        pad_pos_next = pad_pos_reg;
        round_next   = round_reg;
        out_idx_next = out_idx_reg;
        s_ready      = 1'b0;
        m_valid      = 1'b0;

        cmd           = '0;
        cmd.byte_src  = BSRC_ZERO;
        cmd.buf_addr  = pad_pos_reg;
        cmd.round_idx = round_reg;
        cmd.out_idx   = out_idx_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.buf_addr = pos;
                if (s_valid) begin
                    cmd.buf_we = 1'b1;
                    if (s_kind == KIND_ABSORB) begin
                        cmd.byte_src  = BSRC_MSG;
                        cmd.count_inc = 1'b1;
                        if (pos == POS_LAST) begin
                            state_next = ST_LOAD;
                            ret_next   = ST_IDLE;
                        end
                    end else begin
                        cmd.byte_src = BSRC_PAD;
                        pad_pos_next = pos + 6'd1;
                        // no room for the length after the pad byte
                        wrap_next    = (pos[5:3] == POS_WRAP);
                        state_next   = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (wrap_reg) begin
                    if (pad_pos_reg == POS_FIRST) begin
                        wrap_next  = 1'b0;
                        state_next = ST_LOAD;
                        ret_next   = ST_PAD;
                    end else begin
                        cmd.buf_we   = 1'b1;
                        pad_pos_next = pad_pos_reg + 6'd1;
                    end
                end else if (pad_pos_reg == POS_LEN) begin
                    state_next = ST_LEN;
                end else begin
                    cmd.buf_we   = 1'b1;
                    pad_pos_next = pad_pos_reg + 6'd1;
                end
            end
            ST_LEN: begin
                cmd.buf_we   = 1'b1;
                cmd.byte_src = BSRC_LEN;
                pad_pos_next = pad_pos_reg + 6'd1;
                if (pad_pos_reg == POS_LAST) begin
                    state_next = ST_LOAD;
                    ret_next   = ST_OUT;
                end
            end
            ST_LOAD: begin
                cmd.work_load = 1'b1;
                round_next    = '0;
                state_next    = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.chain_add = 1'b1;
                state_next    = ret_reg;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == WORD_LAST) begin
                        cmd.msg_clear = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_word_index = out_idx_reg;
    assign m_last_word  = (out_idx_reg == WORD_LAST);

endmodule

### rtl/sha256_dp.sv
// SHA-256 stream hash datapath: block buffer / schedule window, round
// logic, chaining state and byte count. Depends on sha256_pkg.
module sha256_dp import sha256_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  sha_cmd_t    cmd,
    input  logic [7:0]  msg_byte,
    output logic [5:0]  pos,
    output logic [31:0] digest_word
);

    // block buffer, big-endian words; also the 16-word schedule window
    logic [3:0][7:0] blk_reg [16];
    logic [31:0]     work_reg [8];
    logic [31:0]     chain_reg [8];
    logic [63:0]     count_reg;

    logic [63:0] bit_len;
    logic [5:0]  len_shift;
    logic [7:0]  wr_byte;
    logic [31:0] w_cur, w_new;
    logic [31:0] t1, t2;

    assign pos     = count_reg[5:0];
    assign bit_len = {count_reg[60:0], 3'b000};
    assign len_shift = {~cmd.buf_addr[2:0], 3'b000};

    always_comb begin
        case (cmd.byte_src)
            BSRC_MSG:  wr_byte = msg_byte;
            BSRC_PAD:  wr_byte = PAD_BYTE;
            BSRC_ZERO: wr_byte = 8'h00;
            BSRC_LEN:  wr_byte = 8'(bit_len >> len_shift);
            default:   wr_byte = 8'h00;
        endcase
    end

    assign w_cur = blk_reg[0];
    assign w_new = sig1(blk_reg[14]) + blk_reg[9] + sig0(blk_reg[1]) + blk_reg[0];

    assign t1 = work_reg[7] + bsig1(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + K_TABLE[cmd.round_idx] + w_cur;
    assign t2 = bsig0(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]));

    always_ff @(posedge aclk) begin
        if (cmd.buf_we) begin
            blk_reg[cmd.buf_addr[5:2]][~cmd.buf_addr[1:0]] <= wr_byte;
        end else if (cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                blk_reg[i] <= blk_reg[i + 1];
            end
            blk_reg[15] <= w_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.work_load) begin
            work_reg <= chain_reg;
        end else if (cmd.round_en) begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= H_INIT;
            count_reg <= '0;
        end else begin
            if (cmd.msg_clear) begin
                chain_reg <= H_INIT;
            end else if (cmd.chain_add) begin
                for (int i = 0; i < 8; i++) begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
            if (cmd.msg_clear) begin
                count_reg <= '0;
            end else if (cmd.count_inc) begin
                count_reg <= count_reg + 64'd1;
            end
        end
    end

    assign digest_word = chain_reg[cmd.out_idx];

endmodule

### rtl/sha256_stream_hash.sv
// SHA-256 stream hash top level: joins controller and datapath.
// Depends on sha256_pkg, sha256_ctrl and sha256_dp.

// One word is taken at a time. An absorb word is written straight into the block buffer; every 64th
// message byte then holds s_ready low while the block is compressed (a
// load step, 64 rounds on the single round unit, one chaining add). A
// finish word pads byte by byte up to offset 56 (or to the block end plus a
// compression and then to offset 56 when fewer than nine bytes are free),
// writes the 8 length bytes, compresses the block and presents the eight
// digest words h0..h7 on m_*, one per accepted handshake; s_ready returns
// high the cycle after the last word is taken.
module sha256_stream_hash import sha256_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_message_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    sha_cmd_t   cmd;
    logic [5:0] pos;

    sha256_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word_index (m_word_index),
        .m_last_word  (m_last_word),
        .pos          (pos),
        .cmd          (cmd)
    );

    sha256_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .msg_byte    (s_message_byte),
        .pos         (pos),
        .digest_word (m_digest_word)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output channels active together");

    a_finish_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind == KIND_FINISH) |=> !s_ready)
        else $error("input taken again right after a finish word");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_word) |=> (s_ready && !m_valid))
        else $error("engine not idle after the last digest word");

    a_clear_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_word) |=> (pos == POS_FIRST))
        else $error("byte count not cleared after digest");

endmodule
